/* src/smdg_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// smdg_pkg: shared types and constants of the sine motor drive generator
// widths, codes, handshake structs and the quarter-wave sine table
// ----------------------------------------------------------------------------
package smdg_pkg;

    // table depth is a power of two so the phase splits into quadrant and offset
    localparam int SINE_TABLE_DEPTH = 256;
    localparam int PERIOD_BITS      = 24;

    localparam int ELAPSED_BITS    = 32;
    localparam int TICK_BITS       = 16;
    localparam int LEVEL_BITS      = 16;
    localparam int CFG_DATA_BITS   = 24;
    localparam int CFG_INDEX_BITS  = 2;
    localparam int DRIVE_BITS      = 16;
    localparam int SINE_MAG_BITS   = 15;
    localparam int PHASE_BITS      = $clog2(4 * SINE_TABLE_DEPTH);
    localparam int QUAD_BITS       = $clog2(SINE_TABLE_DEPTH);
    localparam int TABLE_ADDR_BITS = $clog2(SINE_TABLE_DEPTH + 1);
    localparam int DIV_STEPS       = ELAPSED_BITS + PHASE_BITS;
    localparam int DIV_CNT_BITS    = $clog2(DIV_STEPS);
    localparam int PRODUCT_BITS    = SINE_MAG_BITS + LEVEL_BITS + 1;

    localparam logic [SINE_MAG_BITS-1:0] SINE_MAG_MAX = '1;
    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
    localparam logic [63:0] Q30_HALF    = 64'd1 << 29;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        REG_MODE      = 2'd0,
        REG_LEVEL     = 2'd1,
        REG_AMPLITUDE = 2'd2,
        REG_PERIOD    = 2'd3
    } cfg_reg_t;

    typedef enum logic [1:0] {
        MODE_CONSTANT  = 2'd0,
        MODE_OSCILLATE = 2'd1,
        MODE_DANCE     = 2'd2
    } mode_t;

    typedef enum logic [1:0] {
        CORE_IDLE,
        CORE_DIVIDE,
        CORE_SHAPE,
        CORE_DONE
    } core_state_t;

    typedef struct packed {
        logic                    start;
        logic [ELAPSED_BITS-1:0] dividend;
        logic [PERIOD_BITS-1:0]  divisor;
    } div_req_t;

    typedef struct packed {
        logic                  done;
        logic                  zero;
        logic [PHASE_BITS-1:0] phase;
    } div_rsp_t;

    typedef struct packed {
        logic                         done;
        logic signed [DRIVE_BITS-1:0] drive;
    } shape_rsp_t;

    typedef logic [SINE_MAG_BITS-1:0] quarter_table_t [0:SINE_TABLE_DEPTH];

    // two q30 multiplies, raising the odd power by two
    function automatic logic [63:0] series_power(input logic [63:0] term,
                                                 input logic [63:0] x);
        logic [63:0] t;
        t = (term * x) >> 30;
        return (t * x) >> 30;
    endfunction

    // round(32767*sin(pi/2*i/depth)) through a q30 odd-power series up to x^13
    function automatic quarter_table_t build_quarter_table();
        quarter_table_t    t;
        logic [63:0]        x;
        logic [63:0]        term;
        logic [63:0]        v;
        logic signed [63:0] sum;
        for (int i = 0; i <= SINE_TABLE_DEPTH; i++)
        begin
            x    = (64'(i) * HALF_PI_Q30) / SINE_TABLE_DEPTH;
            term = x;
            sum  = $signed(x);
            term = series_power(term, x) / 64'd6;
            sum  = sum - $signed(term);
            term = series_power(term, x) / 64'd20;
            sum  = sum + $signed(term);
            term = series_power(term, x) / 64'd42;
            sum  = sum - $signed(term);
            term = series_power(term, x) / 64'd72;
            sum  = sum + $signed(term);
            term = series_power(term, x) / 64'd110;
            sum  = sum - $signed(term);
            term = series_power(term, x) / 64'd156;
            sum  = sum + $signed(term);
            if (sum < 0)
            begin
                sum = '0;
            end
            v = ($unsigned(sum) * 64'(SINE_MAG_MAX) + Q30_HALF) >> 30;
            if (v > 64'(SINE_MAG_MAX))
            begin
                v = 64'(SINE_MAG_MAX);
            end
            t[i] = SINE_MAG_BITS'(v);
        end
        return t;
    endfunction

    localparam quarter_table_t QUARTER_TABLE = build_quarter_table();

endpackage
`default_nettype wire

/* src/smdg_divider.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// smdg_divider: bit-serial phase divider
// restoring division of elapsed*4*depth by the period, one quotient bit a cycle
// ----------------------------------------------------------------------------
module smdg_divider (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire smdg_pkg::div_req_t req,
    output smdg_pkg::div_rsp_t     rsp
);
    import smdg_pkg::*;

    logic                    busy_reg, busy_next;
    logic                    done_reg, done_next;
    logic [DIV_CNT_BITS-1:0] count_reg, count_next;
    logic [DIV_STEPS-1:0]    dividend_reg, dividend_next;
    logic [PERIOD_BITS-1:0]  divisor_reg, divisor_next;
    logic [PERIOD_BITS-1:0]  rem_reg, rem_next;
    logic [PHASE_BITS-1:0]   quo_reg, quo_next;

    logic [PERIOD_BITS:0]    trial;
    logic                    fits;

    assign trial = {rem_reg, dividend_reg[DIV_STEPS-1]};
    assign fits  = trial >= {1'b0, divisor_reg};

    always_comb
    begin
        busy_next     = busy_reg;
        done_next     = 1'b0;
        count_next    = count_reg;
        dividend_next = dividend_reg;
        divisor_next  = divisor_reg;
        rem_next      = rem_reg;
        quo_next      = quo_reg;
        if (req.start)
        begin
            busy_next     = 1'b1;
            count_next    = DIV_CNT_BITS'(DIV_STEPS - 1);
            dividend_next = {req.dividend, PHASE_BITS'(0)};
            divisor_next  = req.divisor;
            rem_next      = '0;
        end
        else if (busy_reg)
        begin
            dividend_next = {dividend_reg[DIV_STEPS-2:0], 1'b0};
            rem_next      = fits ? PERIOD_BITS'(trial - {1'b0, divisor_reg})
                                 : PERIOD_BITS'(trial);
            // only the low quotient bits matter: the phase wraps each period
            quo_next      = {quo_reg[PHASE_BITS-2:0], fits};
            count_next    = count_reg - 1'b1;
            if (count_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            count_reg <= '0;
        end
        else
        begin
            busy_reg  <= busy_next;
            done_reg  <= done_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dividend_reg <= dividend_next;
        divisor_reg  <= divisor_next;
        rem_reg      <= rem_next;
        quo_reg      <= quo_next;
    end

    assign rsp.done  = done_reg;
    assign rsp.zero  = (divisor_reg == '0);
    assign rsp.phase = quo_reg;

endmodule
`default_nettype wire

/* src/smdg_shaper.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// smdg_shaper: sine lookup and amplitude scaling
// quadrant mirror of the quarter table, then rounded q1.15 scale and saturate
// ----------------------------------------------------------------------------
module smdg_shaper (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire smdg_pkg::div_rsp_t              phase_in,
    input  wire logic                            apply_amp,
    input  wire logic [smdg_pkg::LEVEL_BITS-1:0] amplitude,
    output smdg_pkg::shape_rsp_t                 rsp
);
    import smdg_pkg::*;

    logic                         lookup_valid_reg;
    logic                         scale_valid_reg;
    logic [SINE_MAG_BITS-1:0]     mag_reg, mag_next;
    logic                         neg_reg, neg_next;
    logic                         apply_reg;
    logic signed [DRIVE_BITS-1:0] drive_reg, drive_next;

    logic [1:0]                   quad;
    logic [TABLE_ADDR_BITS-1:0]   addr;
    logic [PRODUCT_BITS-1:0]      product;
    logic [PRODUCT_BITS-1:0]      scaled;
    logic [SINE_MAG_BITS-1:0]     mag_out;

    // stage one: table read, quadrants one and three read mirrored
    assign quad = phase_in.phase[PHASE_BITS-1 -: 2];
    assign addr = quad[0]
                ? TABLE_ADDR_BITS'(SINE_TABLE_DEPTH)
                  - TABLE_ADDR_BITS'(phase_in.phase[QUAD_BITS-1:0])
                : TABLE_ADDR_BITS'(phase_in.phase[QUAD_BITS-1:0]);

    always_comb
    begin
        mag_next = phase_in.zero ? '0 : QUARTER_TABLE[addr];
        neg_next = quad[1] & ~phase_in.zero;
    end

    // stage two: |s|*amplitude rounded back to q1.15
    assign product = PRODUCT_BITS'(mag_reg) * PRODUCT_BITS'(amplitude);
    assign scaled  = (product + PRODUCT_BITS'(1 << (SINE_MAG_BITS - 1))) >> SINE_MAG_BITS;

    always_comb
    begin
        if (!apply_reg)
        begin
            mag_out = mag_reg;
        end
        else if (scaled > PRODUCT_BITS'(SINE_MAG_MAX))
        begin
            mag_out = SINE_MAG_MAX;
        end
        else
        begin
            mag_out = SINE_MAG_BITS'(scaled);
        end
        drive_next = neg_reg ? -$signed({1'b0, mag_out}) : $signed({1'b0, mag_out});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lookup_valid_reg <= 1'b0;
            scale_valid_reg  <= 1'b0;
        end
        else
        begin
            lookup_valid_reg <= phase_in.done;
            scale_valid_reg  <= lookup_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (phase_in.done)
        begin
            mag_reg   <= mag_next;
            neg_reg   <= neg_next;
            apply_reg <= apply_amp;
        end
        if (lookup_valid_reg)
        begin
            drive_reg <= drive_next;
        end
    end

    assign rsp.done  = scale_valid_reg;
    assign rsp.drive = drive_reg;

endmodule
`default_nettype wire

/* src/sine_motor_drive_generator.sv */
`timescale 1ns / 1ps
`default_nettype none
// a sine request in oscillate and dance modes passes the sequencer's divide, shape and done
//   states: the bit-serial divider, one quotient bit per dividend bit, then the shaper
// constant mode, unused mode and window ends go straight to the done state
// one request at a time: a new one is taken only once the last result is in the output register
// reset: asynchronous, active low; registers return to mode 0, level and amplitude
//   32768, period 1000; elapsed counter and dance state cleared
// ----------------------------------------------------------------------------
// sine_motor_drive_generator: motor drive waveform generator
// constant level, amplitude-scaled sine, or a dance sine with halving period
// ----------------------------------------------------------------------------
module sine_motor_drive_generator (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    // configuration write port
    input  wire logic                                cfg_write,
    input  wire logic [smdg_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  wire logic [smdg_pkg::CFG_DATA_BITS-1:0]  cfg_data,
    // step requests
    input  wire logic                                step_valid,
    output logic                                     step_ready,
    input  wire logic [smdg_pkg::TICK_BITS-1:0]      ticks_passed,
    // drive results
    output logic                                     result_valid,
    input  wire logic                                result_ready,
    output logic signed [smdg_pkg::DRIVE_BITS-1:0]   drive,
    output logic                                     window_end
);
    import smdg_pkg::*;

    // configuration registers
    logic [1:0]               mode_reg;
    logic [LEVEL_BITS-1:0]    level_reg;
    logic [LEVEL_BITS-1:0]    amplitude_reg;
    logic [PERIOD_BITS-1:0]   period_reg;

    // waveform state
    logic [ELAPSED_BITS-1:0]  elapsed_reg, elapsed_next;
    logic [PERIOD_BITS-1:0]   dance_period_reg, dance_period_next;
    logic                     dance_running_reg, dance_running_next;

    // core control and the result waiting for the output register
    core_state_t              core_state_reg, core_state_next;
    logic                     apply_amp_reg, apply_amp_next;
    logic signed [DRIVE_BITS-1:0] res_drive_reg, res_drive_next;
    logic                     res_wend_reg, res_wend_next;

    // output register
    logic                     result_valid_reg, result_valid_next;
    logic signed [DRIVE_BITS-1:0] drive_reg, drive_next;
    logic                     window_end_reg, window_end_next;

    div_req_t                 div_req;
    div_rsp_t                 div_rsp;
    shape_rsp_t               shape_rsp;

    // saturating add of the ticks to the elapsed counter
    logic [ELAPSED_BITS:0]    tick_sum;
    logic [ELAPSED_BITS-1:0]  elapsed_sum;
    logic                     osc_over;
    logic signed [DRIVE_BITS-1:0] level_drive;

    // dance step: a stopped dance restarts from the start period with no ticks
    logic [ELAPSED_BITS-1:0]  dance_elapsed;
    logic [PERIOD_BITS-1:0]   dance_cur;
    logic                     dance_over;
    logic [PERIOD_BITS-1:0]   dance_after;
    logic                     dance_stop;

    assign tick_sum    = {1'b0, elapsed_reg} + (ELAPSED_BITS + 1)'(ticks_passed);
    assign elapsed_sum = tick_sum[ELAPSED_BITS] ? '1 : tick_sum[ELAPSED_BITS-1:0];
    assign osc_over    = elapsed_sum > ELAPSED_BITS'(period_reg);

    // level at or above 1.0 saturates just below it
    assign level_drive = (level_reg > LEVEL_BITS'(SINE_MAG_MAX))
                       ? $signed(DRIVE_BITS'(SINE_MAG_MAX)) : $signed(level_reg);

    assign dance_elapsed = dance_running_reg ? elapsed_sum : '0;
    assign dance_cur     = dance_running_reg ? dance_period_reg : period_reg;
    // window is twice the live start period
    assign dance_over    = {1'b0, dance_elapsed} > ((ELAPSED_BITS + 1)'(period_reg) << 1);
    assign dance_after   = dance_over ? (dance_cur >> 1) : dance_cur;
    // stop once the running period has fallen to a sixteenth of the start
    assign dance_stop    = ((PERIOD_BITS + 4)'(dance_after) << 4)
                           <= (PERIOD_BITS + 4)'(period_reg);

    // configuration writes; the user must write only while idle, the block does not enforce it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= MODE_CONSTANT;
            level_reg     <= LEVEL_BITS'(32768);
            amplitude_reg <= LEVEL_BITS'(32768);
            period_reg    <= PERIOD_BITS'(1000);
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_MODE:      mode_reg      <= cfg_data[1:0];
                REG_LEVEL:     level_reg     <= cfg_data[LEVEL_BITS-1:0];
                REG_AMPLITUDE: amplitude_reg <= cfg_data[LEVEL_BITS-1:0];
                REG_PERIOD:    period_reg    <= PERIOD_BITS'(cfg_data);
                default:       ;
            endcase
        end
    end

    // core sequencer and output register hand-over
    always_comb
    begin
        core_state_next    = core_state_reg;
        elapsed_next       = elapsed_reg;
        dance_period_next  = dance_period_reg;
        dance_running_next = dance_running_reg;
        apply_amp_next     = apply_amp_reg;
        res_drive_next     = res_drive_reg;
        res_wend_next      = res_wend_reg;
        drive_next         = drive_reg;
        window_end_next    = window_end_reg;
        result_valid_next  = result_valid_reg & ~result_ready;
        div_req            = '0;
        step_ready         = 1'b0;

        unique case (core_state_reg)
            CORE_IDLE:
            begin
                step_ready = 1'b1;
                if (step_valid)
                begin
                    res_drive_next  = '0;
                    res_wend_next   = 1'b0;
                    core_state_next = CORE_DONE;
                    case (mode_reg)
                        MODE_CONSTANT:
                        begin
                            res_drive_next = level_drive;
                        end
                        MODE_OSCILLATE:
                        begin
                            if (osc_over)
                            begin
                                elapsed_next  = '0;
                                res_wend_next = 1'b1;
                            end
                            else
                            begin
                                elapsed_next     = elapsed_sum;
                                apply_amp_next   = 1'b1;
                                div_req.start    = 1'b1;
                                div_req.dividend = elapsed_sum;
                                div_req.divisor  = period_reg;
                                core_state_next  = CORE_DIVIDE;
                            end
                        end
                        MODE_DANCE:
                        begin
                            dance_period_next  = dance_after;
                            dance_running_next = ~dance_stop;
                            if (dance_over)
                            begin
                                elapsed_next  = '0;
                                res_wend_next = 1'b1;
                            end
                            else
                            begin
                                elapsed_next     = dance_elapsed;
                                apply_amp_next   = 1'b0;
                                div_req.start    = 1'b1;
                                div_req.dividend = dance_elapsed;
                                div_req.divisor  = dance_cur;
                                core_state_next  = CORE_DIVIDE;
                            end
                        end
                        default:
                        begin
                            // unused mode: zero drive, state kept
                            res_drive_next = '0;
                        end
                    endcase
                end
            end
            CORE_DIVIDE:
            begin
                if (div_rsp.done)
                begin
                    core_state_next = CORE_SHAPE;
                end
            end
            CORE_SHAPE:
            begin
                if (shape_rsp.done)
                begin
                    res_drive_next  = shape_rsp.drive;
                    res_wend_next   = 1'b0;
                    core_state_next = CORE_DONE;
                end
            end
            CORE_DONE:
            begin
                // move on once the output register is free or being emptied
                if (!result_valid_reg || result_ready)
                begin
                    drive_next        = res_drive_reg;
                    window_end_next   = res_wend_reg;
                    result_valid_next = 1'b1;
                    core_state_next   = CORE_IDLE;
                end
            end
            default:
            begin
                core_state_next = CORE_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            core_state_reg    <= CORE_IDLE;
            elapsed_reg       <= '0;
            dance_period_reg  <= '0;
            dance_running_reg <= 1'b0;
            result_valid_reg  <= 1'b0;
        end
        else
        begin
            core_state_reg    <= core_state_next;
            elapsed_reg       <= elapsed_next;
            dance_period_reg  <= dance_period_next;
            dance_running_reg <= dance_running_next;
            result_valid_reg  <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        apply_amp_reg  <= apply_amp_next;
        res_drive_reg  <= res_drive_next;
        res_wend_reg   <= res_wend_next;
        drive_reg      <= drive_next;
        window_end_reg <= window_end_next;
    end

    // phase = floor(elapsed*4*depth/period) mod 4*depth, one bit a cycle
    smdg_divider u_divider (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    // table lookup, quadrant fold and optional amplitude scale
    smdg_shaper u_shaper (
        .clk       (clk),
        .rst_n     (rst_n),
        .phase_in  (div_rsp),
        .apply_amp (apply_amp_reg),
        .amplitude (amplitude_reg),
        .rsp       (shape_rsp)
    );

    assign result_valid = result_valid_reg;
    assign drive        = drive_reg;
    assign window_end   = window_end_reg;

    // the divider only finishes while the sequencer waits for it
    assert property (@(posedge clk) disable iff (!rst_n)
        div_rsp.done |-> core_state_reg == CORE_DIVIDE)
        else $error("divider finished outside the divide state");

    // the shaper only finishes while the sequencer waits for it
    assert property (@(posedge clk) disable iff (!rst_n)
        shape_rsp.done |-> core_state_reg == CORE_SHAPE)
        else $error("shaper finished outside the shape state");

    // a cleared window always gives zero drive
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && window_end |-> drive == '0)
        else $error("window end with nonzero drive");

    // drive stays within the symmetric q1.15 range
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> drive != $signed({1'b1, {(DRIVE_BITS - 1){1'b0}}}))
        else $error("drive reached the negative full-scale code");

    // one request in flight: an accepted request closes the input
    assert property (@(posedge clk) disable iff (!rst_n)
        step_valid && step_ready |=> !step_ready)
        else $error("second request taken while one is in flight");

endmodule
`default_nettype wire

/* sim/drive_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// drive_checker: drive prediction and comparison for the motor drive generator
// follows register writes and step requests, works out each drive result and
// compares every accepted result against the oldest one still owed
// ----------------------------------------------------------------------------
module drive_checker (
    input  logic                                     clk,
    input  logic                                     rst_n,
    input  logic                                     cfg_write,
    input  logic [smdg_pkg::CFG_INDEX_BITS-1:0]      cfg_index,
    input  logic [smdg_pkg::CFG_DATA_BITS-1:0]       cfg_data,
    input  logic                                     step_valid,
    input  logic                                     step_ready,
    input  logic [smdg_pkg::TICK_BITS-1:0]           ticks_passed,
    input  logic                                     result_valid,
    input  logic                                     result_ready,
    input  logic signed [smdg_pkg::DRIVE_BITS-1:0]   drive,
    input  logic                                     window_end,
    output int                                       mismatches,
    output int                                       pending,
    output int                                       checked,
    output int                                       window_ends
);
    import smdg_pkg::*;

    localparam int              FULL_TURN       = 4 * SINE_TABLE_DEPTH;
    localparam longint unsigned HALF_PI_FIX     = 64'd1686629713;
    localparam longint unsigned ELAPSED_CEILING = 64'hFFFF_FFFF;

    typedef struct packed {
        logic signed [DRIVE_BITS-1:0] drive;
        logic                         window_end;
    } drive_result_t;

    logic [1:0]             mode_reg;
    logic [LEVEL_BITS-1:0]  level_reg;
    logic [LEVEL_BITS-1:0]  amplitude_reg;
    logic [PERIOD_BITS-1:0] period_reg;

    longint unsigned elapsed_ticks;
    longint unsigned dance_span;
    logic            dance_on;

    int            quarter_wave [0:SINE_TABLE_DEPTH];
    drive_result_t owed_drives [$];

    // q30 odd-power series up to x^13, rounded to q15 magnitude
    function automatic int quarter_sample(input int i);
        longint unsigned x;
        longint unsigned term;
        longint unsigned mag;
        longint          acc;
        x    = (longint'(i) * HALF_PI_FIX) / SINE_TABLE_DEPTH;
        term = x;
        acc  = longint'(x);
        for (int n = 1; n <= 6; n++)
        begin
            term = ((((term * x) >> 30) * x) >> 30) / longint'(2 * n * (2 * n + 1));
            if (n % 2 == 1)
            begin
                acc = acc - longint'(term);
            end
            else
            begin
                acc = acc + longint'(term);
            end
        end
        if (acc < 0)
        begin
            acc = 0;
        end
        mag = ($unsigned(acc) * 64'd32767 + (64'd1 << 29)) >> 30;
        if (mag > 64'd32767)
        begin
            mag = 64'd32767;
        end
        return int'(mag);
    endfunction

    function automatic int sine_sample(input longint unsigned t, input longint unsigned per);
        longint unsigned ph;
        int              quad;
        int              off;
        if (per == 0)
        begin
            return 0;
        end
        ph   = ((t * FULL_TURN) / per) % FULL_TURN;
        quad = int'(ph / SINE_TABLE_DEPTH);
        off  = int'(ph % SINE_TABLE_DEPTH);
        case (quad)
            0:       return quarter_wave[off];
            1:       return quarter_wave[SINE_TABLE_DEPTH - off];
            2:       return -quarter_wave[off];
            default: return -quarter_wave[SINE_TABLE_DEPTH - off];
        endcase
    endfunction

    function automatic int scaled_sample(input int s, input logic [LEVEL_BITS-1:0] amp);
        longint unsigned mag;
        mag = (longint'(s < 0 ? -s : s) * amp + 64'd16384) >> 15;
        if (mag > 64'd32767)
        begin
            mag = 64'd32767;
        end
        return (s < 0) ? -int'(mag) : int'(mag);
    endfunction

    function automatic void accumulate(input logic [TICK_BITS-1:0] ticks);
        elapsed_ticks = elapsed_ticks + ticks;
        if (elapsed_ticks > ELAPSED_CEILING)
        begin
            elapsed_ticks = ELAPSED_CEILING;
        end
    endfunction

    // one step of the drive generator, updating the elapsed and dance state
    function automatic drive_result_t advance_drive(input logic [TICK_BITS-1:0] ticks);
        drive_result_t r;
        r.drive      = '0;
        r.window_end = 1'b0;
        case (mode_reg)
            MODE_CONSTANT:
            begin
                r.drive = (level_reg > 16'd32767) ? 16'sd32767 : $signed(level_reg);
            end
            MODE_OSCILLATE:
            begin
                accumulate(ticks);
                if (elapsed_ticks > period_reg)
                begin
                    elapsed_ticks = 0;
                    r.window_end  = 1'b1;
                end
                else
                begin
                    r.drive = DRIVE_BITS'(scaled_sample(
                        sine_sample(elapsed_ticks, period_reg), amplitude_reg));
                end
            end
            MODE_DANCE:
            begin
                // a stopped dance restarts and drops this request's ticks
                if (!dance_on)
                begin
                    dance_on      = 1'b1;
                    dance_span    = period_reg;
                    elapsed_ticks = 0;
                end
                else
                begin
                    accumulate(ticks);
                end
                r.drive = DRIVE_BITS'(sine_sample(elapsed_ticks, dance_span));
                if (elapsed_ticks > 2 * longint'(period_reg))
                begin
                    elapsed_ticks = 0;
                    r.window_end  = 1'b1;
                    r.drive       = '0;
                    dance_span    = dance_span >> 1;
                end
                if (dance_span * 16 <= longint'(period_reg))
                begin
                    dance_on = 1'b0;
                end
            end
            default:
            begin
            end
        endcase
        return r;
    endfunction

    initial
    begin
        for (int i = 0; i <= SINE_TABLE_DEPTH; i++)
        begin
            quarter_wave[i] = quarter_sample(i);
        end
    end

    always @(posedge clk or negedge rst_n)
    begin : watch
        drive_result_t want;
        if (!rst_n)
        begin
            mode_reg      = MODE_CONSTANT;
            level_reg     = 16'd32768;
            amplitude_reg = 16'd32768;
            period_reg    = 24'd1000;
            elapsed_ticks = 0;
            dance_span    = 0;
            dance_on      = 1'b0;
            owed_drives.delete();
            mismatches    = 0;
            pending       = 0;
            checked       = 0;
            window_ends   = 0;
        end
        else
        begin
            if (result_valid && result_ready)
            begin
                if (owed_drives.size() == 0)
                begin
                    $error("drive result with no request outstanding: drive %0d window_end %0b",
                           drive, window_end);
                    mismatches++;
                end
                else
                begin
                    want = owed_drives.pop_front();
                    checked++;
                    if (drive !== want.drive)
                    begin
                        $error("drive mismatch: expected %0d, actual %0d", want.drive, drive);
                        mismatches++;
                    end
                    if (window_end !== want.window_end)
                    begin
                        $error("window_end mismatch: expected %0b, actual %0b",
                               want.window_end, window_end);
                        mismatches++;
                    end
                    if (want.window_end)
                    begin
                        window_ends++;
                    end
                end
            end
            if (step_valid && step_ready)
            begin
                owed_drives.push_back(advance_drive(ticks_passed));
            end
            if (cfg_write)
            begin
                case (cfg_reg_t'(cfg_index))
                    REG_MODE:      mode_reg      = cfg_data[1:0];
                    REG_LEVEL:     level_reg     = cfg_data[LEVEL_BITS-1:0];
                    REG_AMPLITUDE: amplitude_reg = cfg_data[LEVEL_BITS-1:0];
                    REG_PERIOD:    period_reg    = cfg_data[PERIOD_BITS-1:0];
                    default:
                    begin
                    end
                endcase
            end
            pending = owed_drives.size();
        end
    end

endmodule

/* sim/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: top-level testbench for the sine motor drive generator
// directed corner requests then randomised register settings and tick streams,
// with sender and receiver pacing varied; results checked by drive_checker
// ----------------------------------------------------------------------------
module tb;
    import smdg_pkg::*;

    // unused mode code, only ever written from here
    localparam logic [1:0]  MODE_UNUSED  = 2'd3;
    // directed part plus the random part
    localparam int          TOTAL_STEPS  = 625;
    // pacing changes every third of the run
    localparam int          PHASE_SPAN   = TOTAL_STEPS / 3;
    // comfortably beyond the longest sine latency
    localparam int          TAIL_CYCLES  = 64;
    // watchdog limit, in nanoseconds
    localparam int unsigned RUN_LIMIT_NS = 10_000_000;

    logic                         clk          = 1'b0;
    logic                         rst_n        = 1'b0;
    logic                         cfg_write    = 1'b0;
    logic [CFG_INDEX_BITS-1:0]    cfg_index    = '0;
    logic [CFG_DATA_BITS-1:0]     cfg_data     = '0;
    logic                         step_valid   = 1'b0;
    logic                         step_ready;
    logic [TICK_BITS-1:0]         ticks_passed = '0;
    logic                         result_valid;
    logic                         result_ready = 1'b0;
    logic signed [DRIVE_BITS-1:0] drive;
    logic                         window_end;

    // figures handed back by the checker
    int mismatches;
    int pending;
    int checked;
    int window_ends;

    // pacing, in percent of cycles spent idle
    int send_idle_pct = 25;
    int recv_idle_pct = 67;

    int                     steps_sent  = 0;
    int                     writes_done = 0;
    logic [1:0]             cur_mode    = MODE_CONSTANT;
    logic [PERIOD_BITS-1:0] cur_period  = 24'd1000;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    sine_motor_drive_generator dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .step_valid   (step_valid),
        .step_ready   (step_ready),
        .ticks_passed (ticks_passed),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .drive        (drive),
        .window_end   (window_end)
    );

    drive_checker drive_check (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .step_valid   (step_valid),
        .step_ready   (step_ready),
        .ticks_passed (ticks_passed),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .drive        (drive),
        .window_end   (window_end),
        .mismatches   (mismatches),
        .pending      (pending),
        .checked      (checked),
        .window_ends  (window_ends)
    );

    // receiver backpressure, redrawn every cycle
    always @(posedge clk)
    begin
        result_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // drop valid and wait until every owed result has been taken
    // pending is looked at on the falling edge so the checker has settled
    task automatic drain_requests();
        step_valid <= 1'b0;
        do @(negedge clk); while (pending != 0);
        @(posedge clk);
    endtask

    // registers are only written once the block has gone quiet
    task automatic configure(input cfg_reg_t idx, input logic [CFG_DATA_BITS-1:0] data);
        drain_requests();
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        cfg_write <= 1'b0;
        if (idx == REG_MODE)
        begin
            cur_mode = data[1:0];
        end
        if (idx == REG_PERIOD)
        begin
            cur_period = data[PERIOD_BITS-1:0];
        end
        writes_done++;
    endtask

    // one step request; valid stays high afterwards unless a gap follows,
    // so back-to-back requests never lower and raise valid in one step
    task automatic push_step(input logic [TICK_BITS-1:0] t);
        if (steps_sent < PHASE_SPAN)
        begin
            send_idle_pct = 25;
            recv_idle_pct = 67;
        end
        else if (steps_sent < 2 * PHASE_SPAN)
        begin
            send_idle_pct = 67;
            recv_idle_pct = 25;
        end
        else
        begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
        end
        if ($urandom_range(99) < send_idle_pct)
        begin
            step_valid <= 1'b0;
            do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
        end
        step_valid   <= 1'b1;
        ticks_passed <= t;
        do @(posedge clk); while (!step_ready);
        steps_sent++;
    endtask

    // q15 register values, weighted towards the saturation edges
    function automatic logic [LEVEL_BITS-1:0] pick_q15();
        case ($urandom_range(5))
            0:       return 16'd0;
            1:       return 16'd32767;
            2:       return 16'd32768;
            3:       return 16'hFFFF;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [1:0] pick_mode();
        int r;
        r = $urandom_range(99);
        if (r < 15)
        begin
            return MODE_CONSTANT;
        end
        else if (r < 55)
        begin
            return MODE_OSCILLATE;
        end
        else if (r < 95)
        begin
            return MODE_DANCE;
        end
        return MODE_UNUSED;
    endfunction

    // mostly short periods so windows close often; zero and full scale now and then
    function automatic logic [PERIOD_BITS-1:0] pick_period();
        case ($urandom_range(9))
            0:       return 24'd0;
            1:       return 24'd1;
            2:       return 24'hFFFFFF;
            3:       return 24'($urandom);
            4, 5:    return 24'($urandom_range(64, 2));
            default: return 24'($urandom_range(4000, 16));
        endcase
    endfunction

    // tick counts sized to the period so sines get sampled across a window
    function automatic logic [TICK_BITS-1:0] pick_ticks();
        longint unsigned span;
        span = ((cur_mode == MODE_DANCE) ? longint'(cur_period) : cur_period / 2) + 1;
        if (span > 65535)
        begin
            span = 65535;
        end
        case ($urandom_range(9))
            0:       return 16'd0;
            1:       return 16'hFFFF;
            2:       return 16'($urandom);
            default: return 16'($urandom_range(32'(span), 0));
        endcase
    endfunction

    initial
    begin : stimulus
        int burst;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // constant mode: reset level saturates, then full scale, zero, top of range
        push_step(16'd0);
        configure(REG_LEVEL, 24'hFFFFFF);
        push_step(16'hFFFF);
        configure(REG_LEVEL, 24'd0);
        push_step(16'h1234);
        configure(REG_LEVEL, 24'd32767);
        push_step(16'd7);

        // oscillate through one reset-default period: zero, peak, trough, wrap,
        // then one tick past the period to close the window
        configure(REG_MODE, 24'(MODE_OSCILLATE));
        push_step(16'd0);
        push_step(16'd250);
        push_step(16'd500);
        push_step(16'd250);
        push_step(16'd1);

        // amplitude over full scale still saturates, zero amplitude silences
        configure(REG_AMPLITUDE, 24'hFFFFFF);
        push_step(16'd125);
        configure(REG_AMPLITUDE, 24'd0);
        push_step(16'd125);
        configure(REG_AMPLITUDE, 24'd16384);
        push_step(16'hFFFF);

        // constant mode in between must leave the elapsed count alone
        configure(REG_MODE, 24'(MODE_CONSTANT));
        push_step(16'd300);
        configure(REG_MODE, 24'(MODE_OSCILLATE));
        push_step(16'd300);

        // zero period: any elapsed time closes the window, sine reads zero
        configure(REG_PERIOD, 24'd0);
        push_step(16'd0);
        push_step(16'd0);
        push_step(16'd3);
        configure(REG_PERIOD, 24'hFFFFFF);
        push_step(16'hFFFF);

        // dance: restart drops its ticks, windows halve the running period,
        // the period register moves mid-dance, the stop is followed by a restart
        configure(REG_PERIOD, 24'd64);
        configure(REG_MODE, 24'(MODE_DANCE));
        push_step(16'd129);
        push_step(16'd20);
        push_step(16'd109);
        configure(REG_PERIOD, 24'd40);
        push_step(16'd100);
        push_step(16'd81);
        push_step(16'd81);
        push_step(16'd81);
        push_step(16'd10);

        // unused mode code gives a zero drive and touches nothing
        configure(REG_MODE, 24'(MODE_UNUSED));
        push_step(16'd9);

        // random part: a fresh register setting, then a burst of ticks under it;
        // upper data bits are filled with noise since the registers are narrower
        while (steps_sent < TOTAL_STEPS)
        begin
            configure(REG_MODE, {22'($urandom), pick_mode()});
            configure(REG_LEVEL, {8'($urandom), pick_q15()});
            configure(REG_AMPLITUDE, {8'($urandom), pick_q15()});
            configure(REG_PERIOD, pick_period());
            burst = (cur_mode == MODE_DANCE) ? $urandom_range(40, 12) : $urandom_range(30, 6);
            repeat (burst)
            begin
                push_step(pick_ticks());
            end
        end

        drain_requests();
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("run covered %0d drive results (%0d of them window ends) over %0d register writes",
                 checked, window_ends, writes_done);
        $display("pacing went from sender-light to receiver-light stalls, then none at all");
        if (mismatches == 0 && pending == 0)
        begin
            $display("sine_motor_drive_generator verification clean");
        end
        else
        begin
            $display("sine_motor_drive_generator verification failed");
        end
        $finish;
    end

    // watchdog against a hung handshake
    initial
    begin : watchdog
        #RUN_LIMIT_NS;
        $display("sine_motor_drive_generator verification failed");
        $finish;
    end

endmodule
